// ===== rtl/gca_pkg.sv =====
package gca_pkg;

  localparam int LEN_BITS     = 6;
  localparam int IN_COST_BITS = 32;
  localparam int INDEX_BITS   = 6;

  localparam logic [INDEX_BITS-1:0] GAP_INDEX = '1;

  typedef enum logic [1:0] {
    DIR_MATCH = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UP,
    ST_LEFT,
    ST_WRITE,
    ST_TB_READ,
    ST_TB_EMIT
  } state_t;

endpackage

// ===== rtl/gca_ram.sv =====
module gca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gap_cost_sequence_alignment_core.sv =====
// channel  | handshake           | fields
// ---------+---------------------+-----------------------------------------------
// cell in  | start & !busy       | p_length q_length gap_cost pair_cost last_cell
// pair out | strobe (one cycle)  | index_p index_q last_pair
//
// A cell is accepted in idle, then takes four steps (match, up, left, write);
// match, up and left share one saturating adder, and up and left compare
// against the running minimum; busy is high for the four steps and during traceback.
// After a last cell, the traceback reads the direction RAM pair by pair
// (registered RAM read, then emit); up to 64 pairs.
// Reset is synchronous; the cost and direction RAMs are not cleared.
// The receiver cannot stall; strobe marks each pair for one cycle.
module gap_cost_sequence_alignment_core #(
  parameter int MAX_P_STATES = 32,
  parameter int MAX_Q_STATES = 32,
  parameter int COST_BITS    = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [gca_pkg::LEN_BITS-1:0]          p_length,
  input  logic [gca_pkg::LEN_BITS-1:0]          q_length,
  input  logic [gca_pkg::IN_COST_BITS-1:0]      gap_cost,
  input  logic [gca_pkg::IN_COST_BITS-1:0]      pair_cost,
  input  logic                                  last_cell,
  output logic                                  strobe,
  output logic signed [gca_pkg::INDEX_BITS-1:0] index_p,
  output logic signed [gca_pkg::INDEX_BITS-1:0] index_q,
  output logic                                  last_pair
);

  localparam int PW = (MAX_P_STATES > 1) ? $clog2(MAX_P_STATES) : 1;
  localparam int QW = (MAX_Q_STATES > 1) ? $clog2(MAX_Q_STATES) : 1;
  localparam int ROW_DEPTH = 2 ** QW;
  localparam int DIR_DEPTH = (2 ** PW) * (2 ** QW);
  localparam logic [63:0] COST_MAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COST_BITS);
  localparam logic [gca_pkg::LEN_BITS-1:0] P_MAX = gca_pkg::LEN_BITS'(MAX_P_STATES);
  localparam logic [gca_pkg::LEN_BITS-1:0] Q_MAX = gca_pkg::LEN_BITS'(MAX_Q_STATES);

  gca_pkg::state_t state, state_next;

  logic [PW-1:0]                 row_pos;
  logic [QW-1:0]                 col_pos;
  logic [COST_BITS-1:0]          held_gap;
  logic [COST_BITS-1:0]          left_cost;
  logic [COST_BITS-1:0]          diag_cost;
  logic [COST_BITS-1:0]          above;
  logic [COST_BITS-1:0]          pair_hold;
  logic [COST_BITS-1:0]          best;
  gca_pkg::dir_t                 dir;
  logic [gca_pkg::LEN_BITS-1:0]  plen;
  logic [gca_pkg::LEN_BITS-1:0]  qlen;
  logic                          last_hold;

  logic [PW-1:0] tb_m;
  logic [QW-1:0] tb_n;
  logic          tb_m_neg;
  logic          tb_n_neg;

  logic                  accept;
  logic                  first_cell;
  logic [COST_BITS-1:0]  add_a;
  logic [COST_BITS-1:0]  add_b;
  logic [COST_BITS:0]    add_raw;
  logic [COST_BITS-1:0]  add_sum;
  logic                  sum_lower;

  logic [COST_BITS-1:0]  row_rdata;
  logic [1:0]            dir_rdata;

  logic                  dec_m;
  logic                  dec_n;
  logic                  m_neg_next;
  logic                  n_neg_next;
  logic                  tb_done;

  logic [QW:0]           col_inc;
  logic [PW:0]           row_inc;

  function automatic logic [COST_BITS-1:0] clamp_cost(
    input logic [gca_pkg::IN_COST_BITS-1:0] v
  );
    logic [63:0] wide;
    wide = 64'(v);
    if (wide > COST_MAX64) begin
      return '1;
    end
    return wide[COST_BITS-1:0];
  endfunction

  function automatic logic [gca_pkg::LEN_BITS-1:0] clamp_len(
    input logic [gca_pkg::LEN_BITS-1:0] v,
    input logic [gca_pkg::LEN_BITS-1:0] maxv
  );
    if (v == '0) begin
      return gca_pkg::LEN_BITS'(1);
    end
    if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

  assign accept     = start && !busy;
  assign first_cell = (row_pos == '0) && (col_pos == '0);

  // shared saturating adder and compare against the running minimum
  assign add_raw   = {1'b0, add_a} + {1'b0, add_b};
  assign add_sum   = add_raw[COST_BITS] ? '1 : add_raw[COST_BITS-1:0];
  assign sum_lower = add_sum < best;

  assign col_inc = {1'b0, col_pos} + (QW + 1)'(1);
  assign row_inc = {1'b0, row_pos} + (PW + 1)'(1);

  gca_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (state == gca_pkg::ST_WRITE),
    .waddr (col_pos),
    .wdata (best),
    .raddr (col_pos),
    .rdata (row_rdata)
  );

  gca_ram #(
    .WIDTH (2),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .we    (state == gca_pkg::ST_WRITE),
    .waddr ({row_pos, col_pos}),
    .wdata (dir),
    .raddr ({tb_m, tb_n}),
    .rdata (dir_rdata)
  );

  // traceback step
  always_comb begin
    dec_m = 1'b0;
    dec_n = 1'b0;
    if (!tb_m_neg && !tb_n_neg) begin
      case (dir_rdata)
        gca_pkg::DIR_MATCH: begin
          dec_m = 1'b1;
          dec_n = 1'b1;
        end
        gca_pkg::DIR_UP: begin
          dec_m = 1'b1;
        end
        default: begin
          dec_n = 1'b1;
        end
      endcase
    end else if (!tb_n_neg) begin
      dec_n = 1'b1;
    end else begin
      dec_m = 1'b1;
    end
    m_neg_next = tb_m_neg || (dec_m && (tb_m == '0));
    n_neg_next = tb_n_neg || (dec_n && (tb_n == '0));
    tb_done    = m_neg_next && n_neg_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gca_pkg::ST_IDLE: begin
        if (start) begin
          state_next = gca_pkg::ST_MATCH;
        end
      end
      gca_pkg::ST_MATCH:   state_next = gca_pkg::ST_UP;
      gca_pkg::ST_UP:      state_next = gca_pkg::ST_LEFT;
      gca_pkg::ST_LEFT:    state_next = gca_pkg::ST_WRITE;
      gca_pkg::ST_WRITE: begin
        state_next = last_hold ? gca_pkg::ST_TB_READ : gca_pkg::ST_IDLE;
      end
      gca_pkg::ST_TB_READ: state_next = gca_pkg::ST_TB_EMIT;
      gca_pkg::ST_TB_EMIT: begin
        state_next = tb_done ? gca_pkg::ST_IDLE : gca_pkg::ST_TB_READ;
      end
      default:             state_next = gca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != gca_pkg::ST_IDLE);
    add_a = held_gap;
    add_b = '0;
    unique case (state)
      gca_pkg::ST_MATCH: begin
        add_a = pair_hold;
        add_b = ((row_pos != '0) && (col_pos != '0)) ? diag_cost : '0;
      end
      gca_pkg::ST_UP: begin
        add_b = above;
      end
      gca_pkg::ST_LEFT: begin
        add_b = (col_pos != '0) ? left_cost : '0;
      end
      default: begin
        add_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gca_pkg::ST_IDLE;
      row_pos   <= '0;
      col_pos   <= '0;
      held_gap  <= '0;
      left_cost <= '0;
      diag_cost <= '0;
      strobe    <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == gca_pkg::ST_TB_EMIT);
      if (accept && first_cell) begin
        held_gap <= clamp_cost(gap_cost);
      end
      if (state == gca_pkg::ST_WRITE) begin
        if (last_hold) begin
          row_pos   <= '0;
          col_pos   <= '0;
          left_cost <= '0;
          diag_cost <= '0;
        end else begin
          diag_cost <= above;
          left_cost <= best;
          if (gca_pkg::LEN_BITS'(col_inc) >= qlen) begin
            col_pos <= '0;
            row_pos <= (gca_pkg::LEN_BITS'(row_inc) >= plen) ? '0 : row_inc[PW-1:0];
          end else begin
            col_pos <= col_inc[QW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pair_hold <= clamp_cost(pair_cost);
      plen      <= clamp_len(p_length, P_MAX);
      qlen      <= clamp_len(q_length, Q_MAX);
      last_hold <= last_cell;
    end
    unique case (state) inside
      gca_pkg::ST_MATCH: begin
        above <= (row_pos != '0) ? row_rdata : '0;
        best  <= add_sum;
        dir   <= gca_pkg::DIR_MATCH;
      end
      gca_pkg::ST_UP, gca_pkg::ST_LEFT: begin
        if (sum_lower) begin
          best <= add_sum;
          dir  <= (state == gca_pkg::ST_UP) ? gca_pkg::DIR_UP : gca_pkg::DIR_LEFT;
        end
      end
      gca_pkg::ST_WRITE: begin
        tb_m     <= row_pos;
        tb_n     <= col_pos;
        tb_m_neg <= 1'b0;
        tb_n_neg <= 1'b0;
      end
      gca_pkg::ST_TB_EMIT: begin
        index_p   <= dec_m ? gca_pkg::INDEX_BITS'(tb_m) : gca_pkg::GAP_INDEX;
        index_q   <= dec_n ? gca_pkg::INDEX_BITS'(tb_n) : gca_pkg::GAP_INDEX;
        last_pair <= tb_done;
        tb_m_neg  <= m_neg_next;
        tb_n_neg  <= n_neg_next;
        if (dec_m && (tb_m != '0)) begin
          tb_m <= tb_m - PW'(1);
        end
        if (dec_n && (tb_n != '0)) begin
          tb_n <= tb_n - QW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == gca_pkg::ST_TB_EMIT))
    else $error("pair transfer without a traceback step");

  a_accept_starts_cell: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == gca_pkg::ST_MATCH))
    else $error("accepted cell did not start the cost steps");

  a_last_pair_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_pair) |=> !strobe)
    else $error("pair transfer after the last pair");

  a_no_double_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !((index_p == gca_pkg::GAP_INDEX) && (index_q == gca_pkg::GAP_INDEX)))
    else $error("pair with a gap on both sides");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import gca_pkg::*;

  localparam int MAX_P        = 32;
  localparam int MAX_Q        = 32;
  localparam int COST_W       = 32;
  localparam int LEN_TOP      = (1 << LEN_BITS) - 1;
  localparam int FILL_LEN     = 6;
  localparam int RANDOM_CELLS = 390;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 40;

  typedef logic [COST_W-1:0] cost_t;

  typedef struct {
    logic [LEN_BITS-1:0]     p_len;
    logic [LEN_BITS-1:0]     q_len;
    logic [IN_COST_BITS-1:0] gap;
    logic [IN_COST_BITS-1:0] pair;
    logic                    last;
    bit                      drain;  // hold this cell until all pairs are back
  } cell_t;

  typedef struct {
    logic signed [INDEX_BITS-1:0] ip;
    logic signed [INDEX_BITS-1:0] iq;
    logic                         last;
  } pair_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          start     = 1'b0;
  logic [LEN_BITS-1:0]           p_length  = '0;
  logic [LEN_BITS-1:0]           q_length  = '0;
  logic [IN_COST_BITS-1:0]       gap_cost  = '0;
  logic [IN_COST_BITS-1:0]       pair_cost = '0;
  logic                          last_cell = 1'b0;
  logic                          busy;
  logic                          strobe;
  logic signed [INDEX_BITS-1:0]  index_p;
  logic signed [INDEX_BITS-1:0]  index_q;
  logic                          last_pair;

  gap_cost_sequence_alignment_core #(
    .MAX_P_STATES(MAX_P),
    .MAX_Q_STATES(MAX_Q),
    .COST_BITS   (COST_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .p_length (p_length),
    .q_length (q_length),
    .gap_cost (gap_cost),
    .pair_cost(pair_cost),
    .last_cell(last_cell),
    .strobe   (strobe),
    .index_p  (index_p),
    .index_q  (index_q),
    .last_pair(last_pair)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  cell_t pending_cells[$];
  pair_t expected_pairs[$];
  int    err_count   = 0;
  int    cycle_count = 0;
  int    cells_done  = 0;
  int    cells_total = 0;
  int    idle_left   = 0;
  int    calm_left   = 0;
  cell_t on_port;

  // shadow of the alignment state
  cost_t row_cost [MAX_Q];
  cost_t left_val;
  cost_t diag_val;
  cost_t gap_held;
  dir_t  dir_mem [MAX_P*MAX_Q];
  int    row_at;
  int    col_at;

  function automatic cost_t cost_sum(input cost_t a, input cost_t b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

  function automatic int fit_len(input logic [LEN_BITS-1:0] raw, input int hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return int'(raw);
  endfunction

  function automatic pair_t mk_pair(input int m, input int n);
    pair_t pr;
    pr.ip   = (m < 0) ? GAP_INDEX : INDEX_BITS'(m);
    pr.iq   = (n < 0) ? GAP_INDEX : INDEX_BITS'(n);
    pr.last = 1'b0;
    return pr;
  endfunction

  // one cell of the cost fill; on the last cell, trace back and queue the pairs
  task automatic align_cell(input cell_t c);
    int    plen, qlen, m, n, i;
    cost_t above, mc, uc, lc, best;
    dir_t  d;
    pair_t trail[$];
    pair_t pr;
    plen = fit_len(c.p_len, MAX_P);
    qlen = fit_len(c.q_len, MAX_Q);
    if (row_at == 0 && col_at == 0) gap_held = c.gap;
    above = (row_at > 0) ? row_cost[col_at] : '0;
    mc = cost_sum(c.pair, (row_at > 0 && col_at > 0) ? diag_val : '0);
    uc = cost_sum(gap_held, above);
    lc = cost_sum(gap_held, (col_at > 0) ? left_val : '0);
    if (mc <= uc && mc <= lc) begin
      best = mc;
      d = DIR_MATCH;
    end else if (uc <= mc && uc <= lc) begin
      best = uc;
      d = DIR_UP;
    end else begin
      best = lc;
      d = DIR_LEFT;
    end
    dir_mem[row_at*MAX_Q + col_at] = d;
    diag_val = above;
    row_cost[col_at] = best;
    left_val = best;
    if (!c.last) begin
      if (col_at + 1 >= qlen) begin
        col_at = 0;
        row_at = (row_at + 1 >= plen) ? 0 : row_at + 1;
      end else begin
        col_at = col_at + 1;
      end
    end else begin
      m = row_at;
      n = col_at;
      row_at = 0;
      col_at = 0;
      left_val = '0;
      diag_val = '0;
      while (m >= 0 && n >= 0) begin
        d = dir_mem[m*MAX_Q + n];
        if (d == DIR_MATCH) begin
          trail = {trail, mk_pair(m, n)};
          m--;
          n--;
        end else if (d == DIR_UP) begin
          trail = {trail, mk_pair(m, -1)};
          m--;
        end else begin
          trail = {trail, mk_pair(-1, n)};
          n--;
        end
      end
      while (n >= 0) begin
        trail = {trail, mk_pair(-1, n)};
        n--;
      end
      while (m >= 0) begin
        trail = {trail, mk_pair(m, -1)};
        m--;
      end
      for (i = 0; i < trail.size(); i++) begin
        pr = trail[i];
        pr.last = (i == trail.size() - 1);
        expected_pairs = {expected_pairs, pr};
      end
    end
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int gap_pick();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    bit    take;
    bit    free;
    cell_t nxt;
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
      row_at = 0;
      col_at = 0;
      left_val = '0;
      diag_val = '0;
      gap_held = '0;
    end else begin
      if (start && !busy) begin
        align_cell(on_port);
        cells_done++;
      end
      free = !start || !busy;
      take = 1'b0;
      if (free) begin
        if (idle_left > 0) idle_left--;
        else if (pending_cells.size() > 0 &&
                 (!pending_cells[0].drain || expected_pairs.size() == 0)) take = 1'b1;
      end
      if (take) begin
        nxt = pending_cells.pop_front();
        on_port = nxt;
        p_length  <= nxt.p_len;
        q_length  <= nxt.q_len;
        gap_cost  <= nxt.gap;
        pair_cost <= nxt.pair;
        last_cell <= nxt.last;
        start     <= 1'b1;
        idle_left = gap_pick();
      end else if (free) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pair_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_pairs.size() == 0) begin
        flag_error($sformatf("pair (%0d,%0d) with nothing expected", index_p, index_q));
      end else begin
        want = expected_pairs.pop_front();
        if (index_p !== want.ip)
          flag_error($sformatf("index_p %0d, expected %0d", index_p, want.ip));
        if (index_q !== want.iq)
          flag_error($sformatf("index_q %0d, expected %0d", index_q, want.iq));
        if (last_pair !== want.last)
          flag_error($sformatf("last_pair %b, expected %b", last_pair, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic put_cell(input int p, input int q, input logic [IN_COST_BITS-1:0] gap,
                          input logic [IN_COST_BITS-1:0] pair, input logic last,
                          input bit drain);
    cell_t c;
    c.p_len = LEN_BITS'(p);
    c.q_len = LEN_BITS'(q);
    c.gap   = gap;
    c.pair  = pair;
    c.last  = last;
    c.drain = drain;
    pending_cells = {pending_cells, c};
  endtask

  // same clamped length, different encodings
  function automatic int raw_len(input int n, input int hi);
    if (n == 1 && $urandom_range(0, 3) == 0) return 0;
    if (n == hi && $urandom_range(0, 2) == 0) return $urandom_range(hi + 1, LEN_TOP);
    return n;
  endfunction

  function automatic logic [IN_COST_BITS-1:0] pick_cost(input int mode);
    case (mode)
      0:       return IN_COST_BITS'($urandom_range(0, 6)) << 16;
      1:       return $urandom_range(0, 32'h0008_0000);
      2:       return $urandom();
      default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  // kind 0: normal set, 1: last flag early, 2: no last flag (wraps to origin)
  task automatic add_set(input int p, input int q, input int kind, input bit drain);
    int total, stop, k, mode, r;
    logic [IN_COST_BITS-1:0] gap;
    r = $urandom_range(0, 99);
    mode = (r < 50) ? 0 : (r < 80) ? 1 : (r < 93) ? 2 : 3;
    gap = pick_cost(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : mode);
    total = p * q;
    stop = (kind == 1) ? $urandom_range(0, total - 1) : total - 1;
    for (k = 0; k <= stop; k++)
      put_cell(raw_len(p, MAX_P), raw_len(q, MAX_Q), (k == 0) ? gap : $urandom(),
               pick_cost(mode), (kind != 2) && (k == stop), drain && (k == 0));
  endtask

  // lengths vary on every cell but stay inside the first set's area,
  // closed by a last flag
  task automatic add_jitter();
    int n, k;
    n = $urandom_range(3, 12);
    for (k = 0; k < n; k++)
      put_cell($urandom_range(0, FILL_LEN), $urandom_range(0, FILL_LEN), $urandom(),
               pick_cost($urandom_range(0, 3)), k == n - 1, 1'b0);
  endtask

  initial begin
    int i, j, r, p, q, kind, base;
    // 6x6 set first: fills every cost and direction entry the varying-length
    // cells can reach; zero gap and top pair cost trace all up, then all left
    for (i = 0; i < FILL_LEN * FILL_LEN; i++)
      put_cell(FILL_LEN, FILL_LEN, '0, '1, i == FILL_LEN * FILL_LEN - 1, 1'b0);

    // lengths 0 and 63 clamp; single cells with last flag
    put_cell(0, 0, 32'd0, 32'd0, 1'b1, 1'b1);
    put_cell(LEN_TOP, LEN_TOP, 32'h0005_0000, '1, 1'b1, 1'b0);
    // 1x2 set without last flag wraps, the next one closes
    put_cell(1, 2, 32'h0001_0000, 32'h0003_0000, 1'b0, 1'b0);
    put_cell(1, 2, '1, 32'h0000_8000, 1'b0, 1'b0);
    put_cell(1, 2, 32'h0000_4000, 32'h0001_0000, 1'b0, 1'b0);
    put_cell(1, 2, '1, 32'h0009_0000, 1'b1, 1'b0);
    // every sum is at the top cost value
    for (i = 0; i < 4; i++)
      put_cell(2, 2, '1, '1, i == 3, 1'b0);
    // cheap diagonal
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        put_cell(3, 3, 32'h0002_0000, (i == j) ? 32'd0 : 32'h0009_0000,
                 i == 2 && j == 2, 1'b0);
    // q length shrinks from 3 to 2 after the first row
    for (i = 0; i < 3; i++)
      put_cell(2, 3, 32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0);
    put_cell(2, 2, 32'h0007_0000, 32'h0000_0001, 1'b0, 1'b0);
    put_cell(2, 2, 32'h0007_0000, 32'h0003_0000, 1'b1, 1'b0);

    base = pending_cells.size();
    while (pending_cells.size() - base < RANDOM_CELLS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_jitter();
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1)) begin
            p = $urandom_range(8, MAX_P);
            q = $urandom_range(1, 2);
          end else begin
            p = $urandom_range(1, 2);
            q = $urandom_range(8, MAX_Q);
          end
        end else begin
          p = $urandom_range(1, 6);
          q = $urandom_range(1, 6);
        end
        kind = (r < 14) ? 1 : (r < 19) ? 2 : 0;
        add_set(p, q, kind, $urandom_range(0, 29) == 0);
      end
    end
    cells_total = pending_cells.size();

    while (cells_done < cells_total) @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gca_pkg.sv
rtl/gca_ram.sv
rtl/gap_cost_sequence_alignment_core.sv
test/tb_top.sv
